// ===== hw/rtl/wave_equation_rk4_stencil_core_assert.svh =====
// assertion macros used by the stencil core sequencer rtl
// no dependencies
`ifndef WAVE_EQUATION_RK4_STENCIL_CORE_ASSERT_SVH
`define WAVE_EQUATION_RK4_STENCIL_CORE_ASSERT_SVH

// same-cycle implication
`define WERS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wers assertion failed");

// next-cycle implication
`define WERS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wers assertion failed");

`endif

// ===== hw/rtl/wers_pkg.sv =====
// types, codes and arithmetic helpers for the wave equation stencil core
// no dependencies
package wers_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 38;
    localparam int COEF_W     = 6;
    localparam int TAPS       = 5;
    localparam int DRAIN_CYC  = 10;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] REG_POINTS = 2'd0;
    localparam logic [1:0] REG_DT     = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_STEPS  = 2'd3;

    localparam logic signed [COEF_W-1:0] STENCIL_COEF [TAPS] = '{
        -6'sd1, 6'sd16, -6'sd30, 6'sd16, -6'sd1
    };

    typedef struct packed {
        logic [1:0]               operation;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] phi_in;
        logic signed [DATA_W-1:0] pi_in;
    } t_in;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] phi_out;
        logic signed [DATA_W-1:0] pi_out;
    } t_out;

    typedef struct packed {
        logic             issue;
        logic             pv;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] p;
        logic [1:0]       sweep;
    } t_ctl;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] p;
        logic [1:0]       sweep;
    } t_tag;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/wers_cell.sv =====
// one cell of the transposed five-point stencil chain
// depends on wers_pkg
module wers_cell
    import wers_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic signed [ACC_W-1:0]  i_acc,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_prod;

    assign w_prod = ACC_W'(i_x) * ACC_W'(i_coef);

    always_ff @(posedge i_clk) begin
        r_acc <= i_acc + w_prod;
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/wers_ctrl.sv =====
// run sequencer: steps, sweeps and point walk with pipeline drain
// depends on wers_pkg and the assertion macro header
module wers_ctrl
    import wers_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [CNT_W-1:0] i_points,
    input  logic [15:0]      i_steps,
    output t_ctl             o_ctl,
    output logic             o_run,
    output logic             o_fin
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_c, n_c;
    logic [IDX_W-1:0] r_a, n_a;
    logic [1:0]       r_sweep, n_sweep;
    logic [15:0]      r_left, n_left;
    logic [3:0]       r_dcnt, n_dcnt;
    logic [CNT_W-1:0] w_clamp;

    always_comb begin
        if (i_points < CNT_W'(5)) begin
            w_clamp = CNT_W'(5);
        end else if (i_points > CNT_W'(MAX_POINTS)) begin
            w_clamp = CNT_W'(MAX_POINTS);
        end else begin
            w_clamp = i_points;
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_c     = r_c;
        n_a     = r_a;
        n_sweep = r_sweep;
        n_left  = r_left;
        n_dcnt  = r_dcnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_n     = w_clamp;
                    n_c     = '0;
                    n_a     = IDX_W'(w_clamp - CNT_W'(2));
                    n_sweep = '0;
                    n_left  = i_steps;
                    n_state = (i_steps == 16'd0) ? ST_FIN : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                n_c = r_c + CNT_W'(1);
                n_a = ({1'b0, r_a} == r_n - CNT_W'(1)) ? '0 : r_a + IDX_W'(1);
                if (r_c == r_n + CNT_W'(3)) begin
                    n_dcnt  = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'(DRAIN_CYC - 1)) begin
                    n_c     = '0;
                    n_a     = IDX_W'(r_n - CNT_W'(2));
                    n_sweep = r_sweep + 2'd1;
                    n_state = ST_SWEEP;
                    if (r_sweep == 2'd3) begin
                        n_left = r_left - 16'd1;
                        if (r_left == 16'd1) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= CNT_W'(MAX_POINTS);
            r_c     <= '0;
            r_a     <= '0;
            r_sweep <= '0;
            r_left  <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_c     <= n_c;
            r_a     <= n_a;
            r_sweep <= n_sweep;
            r_left  <= n_left;
            r_dcnt  <= n_dcnt;
        end
    end

    assign o_ctl.issue = (r_state == ST_SWEEP);
    assign o_ctl.pv    = (r_state == ST_SWEEP) && (r_c >= CNT_W'(4));
    assign o_ctl.a     = r_a;
    assign o_ctl.p     = IDX_W'(r_c - CNT_W'(4));
    assign o_ctl.sweep = r_sweep;
    assign o_run       = (r_state != ST_IDLE);
    assign o_fin       = (r_state == ST_FIN);

`include "wave_equation_rk4_stencil_core_assert.svh"

    `WERS_ASSERT_NXT(a_fin_idle, i_clk, i_rst_n, r_state == ST_FIN, r_state == ST_IDLE)
    `WERS_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == ST_SWEEP, r_c <= r_n + CNT_W'(3))
    `WERS_ASSERT_IMP(a_drain_quiet, i_clk, i_rst_n, r_state == ST_DRAIN, !o_ctl.pv)
    `WERS_ASSERT_NXT(a_zero_steps, i_clk, i_rst_n, r_state == ST_IDLE && i_go && i_steps == 16'd0,
        r_state == ST_FIN)

endmodule

// ===== hw/rtl/wers_datapath.sv =====
// point stores, stage banks, stencil cell chain and rk4 update pipeline
// depends on wers_pkg and wers_cell
module wers_datapath
    import wers_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic                     i_load,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_phi,
    input  logic signed [DATA_W-1:0] i_pi,
    input  logic [16:0]              i_dt,
    input  logic [31:0]              i_scale,
    output logic signed [DATA_W-1:0] o_rd_phi,
    output logic signed [DATA_W-1:0] o_rd_pi
);

    logic signed [DATA_W-1:0] m_disp [MAX_POINTS];
    logic signed [DATA_W-1:0] m_vel  [MAX_POINTS];
    logic signed [DATA_W-1:0] m_sd   [2*MAX_POINTS];
    logic signed [DATA_W-1:0] m_sv   [2*MAX_POINTS];
    logic signed [DATA_W-1:0] m_sumd [MAX_POINTS];
    logic signed [DATA_W-1:0] m_sumv [MAX_POINTS];

    t_tag w_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8, r_t9;

    logic [IDX_W-1:0]         w_addr_b;
    logic                     w_rb;
    logic signed [DATA_W-1:0] r_dsa, r_dsb, r_vs, r_sd, r_sv, r_sumd, r_sumv;

    logic signed [DATA_W-1:0] w_x;
    logic signed [ACC_W-1:0]  w_acc [TAPS+1];

    logic signed [17:0]       w_dt;
    logic signed [DATA_W-1:0] r2_sd, r2_sv, r2_kd, r2_sumd, r2_sumv;
    logic signed [54:0]       r3_ph, r3_pl;
    logic signed [DATA_W-1:0] r3_sd, r3_sv, r3_kd, r3_sumd, r3_sumv;
    logic signed [70:0]       w_full;
    logic signed [DATA_W-1:0] r4_kd, r4_kv, r4_sd, r4_sv, r4_sumd, r4_sumv;
    logic                     w_w2;
    logic signed [49:0]       r5_pd, r5_pv;
    logic signed [DATA_W-1:0] r5_sd, r5_sv, r5_sumd, r5_sumv;
    logic signed [49:0]       w_shd, w_shv;
    logic signed [DATA_W-1:0] r6_std, r6_stv, r6_sumd, r6_sumv, r6_sd, r6_sv;
    logic signed [49:0]       r6_pfd, r6_pfv;
    logic signed [32:0]       w_yd, w_yv;
    logic signed [34:0]       w_ud, w_uv;
    logic [17:0]              r7_ad, r7_av;
    logic [15:0]              r7_bd, r7_bv;
    logic                     r7_nd, r7_nv;
    logic signed [DATA_W-1:0] r7_sd, r7_sv;
    logic [32:0]              r8_q1d, r8_q1v;
    logic [17:0]              r8_q2d, r8_q2v;
    logic [38:0]              w_md, w_mv;
    logic                     r8_nd, r8_nv;
    logic signed [DATA_W-1:0] r8_sd, r8_sv;
    logic [33:0]              w_qd, w_qv;
    logic signed [35:0]       w_dd, w_dv;
    logic signed [DATA_W-1:0] r9_nd, r9_nv;

    logic                     w_swr;
    logic                     w_stw;
    logic [IDX_W-1:0]         w_waddr;
    logic signed [DATA_W-1:0] w_wphi, w_wpi;

    // issue: tag and read ports
    assign w_t0.v     = i_ctl.pv;
    assign w_t0.p     = i_ctl.p;
    assign w_t0.sweep = i_ctl.sweep;
    assign w_addr_b   = i_ctl.issue ? i_ctl.p : i_index;
    assign w_rb       = (i_ctl.sweep == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
            r_t6 <= '0;
            r_t7 <= '0;
            r_t8 <= '0;
            r_t9 <= '0;
        end else begin
            r_t1 <= w_t0;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= r_t4;
            r_t6 <= r_t5;
            r_t7 <= r_t6;
            r_t8 <= r_t7;
            r_t9 <= r_t8;
        end
    end

    // state stores: load writes, final rk4 update writes
    assign w_swr   = r_t9.v && (r_t9.sweep == 2'd3);
    assign w_waddr = i_load ? i_index : r_t9.p;
    assign w_wphi  = i_load ? i_phi : r9_nd;
    assign w_wpi   = i_load ? i_pi : r9_nv;

    always_ff @(posedge i_clk) begin
        if (i_load || w_swr) begin
            m_disp[w_waddr] <= w_wphi;
            m_vel[w_waddr]  <= w_wpi;
        end
        r_dsa <= m_disp[i_ctl.a];
        r_dsb <= m_disp[w_addr_b];
        r_vs  <= m_vel[w_addr_b];
    end

    // stage banks and running sums
    assign w_stw = r_t6.v && (r_t6.sweep != 2'd3);

    always_ff @(posedge i_clk) begin
        if (w_stw) begin
            m_sd[{r_t6.sweep[0], r_t6.p}] <= r6_std;
            m_sv[{r_t6.sweep[0], r_t6.p}] <= r6_stv;
            m_sumd[r_t6.p]                <= r6_sumd;
            m_sumv[r_t6.p]                <= r6_sumv;
        end
        r_sd   <= m_sd[{w_rb, i_ctl.a}];
        r_sv   <= m_sv[{w_rb, i_ctl.p}];
        r_sumd <= m_sumd[i_ctl.p];
        r_sumv <= m_sumv[i_ctl.p];
    end

    // stencil chain
    assign w_x         = (r_t1.sweep == 2'd0) ? r_dsa : r_sd;
    assign w_acc[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        wers_cell u_cell (
            .i_clk  (i_clk),
            .i_x    (w_x),
            .i_coef (STENCIL_COEF[k]),
            .i_acc  (w_acc[k+1]),
            .o_acc  (w_acc[k])
        );
    end

    assign w_dt   = $signed({1'b0, i_dt});
    assign w_full = (71'(r3_ph) <<< 16) + 71'(r3_pl);
    assign w_w2   = (r_t4.sweep == 2'd1) || (r_t4.sweep == 2'd2);
    assign w_shd  = (r_t5.sweep == 2'd2) ? (r5_pd >>> 16) : (r5_pd >>> 17);
    assign w_shv  = (r_t5.sweep == 2'd2) ? (r5_pv >>> 16) : (r5_pv >>> 17);
    assign w_yd   = $signed(r6_pfd[49:17]);
    assign w_yv   = $signed(r6_pfv[49:17]);
    assign w_ud   = w_yd[32] ? (35'sd2 - 35'(w_yd)) : 35'(w_yd);
    assign w_uv   = w_yv[32] ? (35'sd2 - 35'(w_yv)) : 35'(w_yv);
    assign w_md   = 39'(19'(r7_ad) + 19'(r7_bd)) * 39'd699051;
    assign w_mv   = 39'(19'(r7_av) + 19'(r7_bv)) * 39'd699051;
    assign w_qd   = 34'(r8_q1d) + 34'(r8_q2d);
    assign w_qv   = 34'(r8_q1v) + 34'(r8_q2v);
    assign w_dd   = r8_nd ? -$signed({2'b00, w_qd}) : $signed({2'b00, w_qd});
    assign w_dv   = r8_nv ? -$signed({2'b00, w_qv}) : $signed({2'b00, w_qv});

    always_ff @(posedge i_clk) begin
        // align centre words with the chain output
        r2_sd   <= r_dsb;
        r2_sv   <= r_vs;
        r2_kd   <= (r_t1.sweep == 2'd0) ? r_vs : r_sv;
        r2_sumd <= (r_t1.sweep == 2'd0) ? '0 : r_sumd;
        r2_sumv <= (r_t1.sweep == 2'd0) ? '0 : r_sumv;
        // stencil sum times scale, split in halves
        r3_ph   <= 55'(w_acc[0]) * 55'($signed({1'b0, i_scale[31:16]}));
        r3_pl   <= 55'(w_acc[0]) * 55'($signed({1'b0, i_scale[15:0]}));
        r3_sd   <= r2_sd;
        r3_sv   <= r2_sv;
        r3_kd   <= r2_kd;
        r3_sumd <= r2_sumd;
        r3_sumv <= r2_sumv;
        // rates
        r4_kv   <= sat32(72'(w_full >>> 16));
        r4_kd   <= r3_kd;
        r4_sd   <= r3_sd;
        r4_sv   <= r3_sv;
        r4_sumd <= r3_sumd;
        r4_sumv <= r3_sumv;
        // weighted sums and rate times dt
        r5_sumd <= sat32(72'(r4_sumd) + (w_w2 ? (72'(r4_kd) <<< 1) : 72'(r4_kd)));
        r5_sumv <= sat32(72'(r4_sumv) + (w_w2 ? (72'(r4_kv) <<< 1) : 72'(r4_kv)));
        r5_pd   <= 50'(r4_kd) * 50'(w_dt);
        r5_pv   <= 50'(r4_kv) * 50'(w_dt);
        r5_sd   <= r4_sd;
        r5_sv   <= r4_sv;
        // next stage values, final sum times dt
        r6_std  <= sat32(72'(r5_sd) + 72'(w_shd));
        r6_stv  <= sat32(72'(r5_sv) + 72'(w_shv));
        r6_sumd <= r5_sumd;
        r6_sumv <= r5_sumv;
        r6_pfd  <= 50'(r5_sumd) * 50'(w_dt);
        r6_pfv  <= 50'(r5_sumv) * 50'(w_dt);
        r6_sd   <= r5_sd;
        r6_sv   <= r5_sv;
        // floor divide by three on the magnitude
        r7_ad   <= w_ud[33:16];
        r7_bd   <= w_ud[15:0];
        r7_av   <= w_uv[33:16];
        r7_bv   <= w_uv[15:0];
        r7_nd   <= w_yd[32];
        r7_nv   <= w_yv[32];
        r7_sd   <= r6_sd;
        r7_sv   <= r6_sv;
        r8_q1d  <= 33'(r7_ad) * 33'd21845;
        r8_q1v  <= 33'(r7_av) * 33'd21845;
        r8_q2d  <= w_md[38:21];
        r8_q2v  <= w_mv[38:21];
        r8_nd   <= r7_nd;
        r8_nv   <= r7_nv;
        r8_sd   <= r7_sd;
        r8_sv   <= r7_sv;
        r9_nd   <= sat32(72'(r8_sd) + 72'(w_dd));
        r9_nv   <= sat32(72'(r8_sv) + 72'(w_dv));
    end

    assign o_rd_phi = r_dsb;
    assign o_rd_pi  = r_vs;

endmodule

// ===== hw/rtl/wave_equation_rk4_stencil_core.sv =====
// a new load or read word is taken every cycle while busy is low; a read
// result appears in the cycle after its word is accepted
// in a run, every rk4 stage walks the grid through the five-cell stencil chain,
// then drains the update pipeline
// synchronous active-low reset restores the register defaults and idles the
// sequencer; the point stores are not cleared
module wave_equation_rk4_stencil_core
    import wers_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_word,
    output logic        o_done,
    output t_out        o_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_points;
    logic [16:0]      r_dt;
    logic [31:0]      r_scale;
    logic [15:0]      r_steps;
    logic             r_rd_pend;

    logic                     w_acc;
    logic                     w_go;
    logic                     w_load;
    logic                     w_run;
    logic                     w_fin;
    t_ctl                     w_ctl;
    logic signed [DATA_W-1:0] w_rd_phi, w_rd_pi;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= CNT_W'(MAX_POINTS);
            r_dt     <= 17'd66;
            r_scale  <= 32'd218431488;
            r_steps  <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_POINTS: r_points <= pwdata[CNT_W-1:0];
                REG_DT:     r_dt     <= pwdata[16:0];
                REG_SCALE:  r_scale  <= pwdata;
                REG_STEPS:  r_steps  <= pwdata[15:0];
                default:    r_steps  <= r_steps;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POINTS: prdata = 32'(r_points);
            REG_DT:     prdata = 32'(r_dt);
            REG_SCALE:  prdata = r_scale;
            REG_STEPS:  prdata = 32'(r_steps);
            default:    prdata = '0;
        endcase
    end

    assign busy   = w_run;
    assign w_acc  = start && !busy;
    assign w_go   = w_acc && (i_word.operation == OP_RUN);
    assign w_load = w_acc && (i_word.operation == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= w_acc && (i_word.operation == OP_READ);
        end
    end

    wers_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_points (r_points),
        .i_steps  (r_steps),
        .o_ctl    (w_ctl),
        .o_run    (w_run),
        .o_fin    (w_fin)
    );

    wers_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_load   (w_load),
        .i_index  (i_word.index),
        .i_phi    (i_word.phi_in),
        .i_pi     (i_word.pi_in),
        .i_dt     (r_dt),
        .i_scale  (r_scale),
        .o_rd_phi (w_rd_phi),
        .o_rd_pi  (w_rd_pi)
    );

    assign o_done         = r_rd_pend || w_fin;
    assign o_word.kind    = w_fin ? KIND_DONE : KIND_READ;
    assign o_word.phi_out = w_fin ? '0 : w_rd_phi;
    assign o_word.pi_out  = w_fin ? '0 : w_rd_pi;

endmodule

// ===== bench/wave_equation_rk4_stencil_core_checker.sv =====
// checker for the wave equation stencil core: watches words in, register writes and results,
// predicts each result with its own rk4 grid model and compares field by field
// depends on wers_pkg
module wave_equation_rk4_stencil_core_checker
    import wers_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in         i_word,
    input  logic        i_done,
    input  t_out        i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_failures,
    output int          o_pending
);

    logic [10:0] grid_points;
    logic [16:0] dt_q;
    logic [31:0] scale_q;
    logic [15:0] step_count;

    int phi_grid [MAX_POINTS];
    int vel_grid [MAX_POINTS];

    t_out result_queue [$];

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int active_points();
        if (grid_points < 5) return 5;
        if (grid_points > MAX_POINTS) return MAX_POINTS;
        return grid_points;
    endfunction

    task automatic advance_grid(input int n);
        int     stage_phi [MAX_POINTS];
        int     stage_vel [MAX_POINTS];
        int     acc_phi [MAX_POINTS];
        int     acc_vel [MAX_POINTS];
        int     rate_phi [MAX_POINTS];
        int     rate_vel [MAX_POINTS];
        longint dt;
        longint hi;
        longint lo;
        longint w;
        longint den;
        longint lap;
        dt = longint'(dt_q);
        hi = longint'(scale_q[31:16]);
        lo = longint'(scale_q[15:0]);
        for (int j = 0; j < n; j++) begin
            stage_phi[j] = phi_grid[j];
            stage_vel[j] = vel_grid[j];
            acc_phi[j] = 0;
            acc_vel[j] = 0;
        end
        for (int s = 0; s < 4; s++) begin
            w = (s == 0 || s == 3) ? 1 : 2;
            den = (s < 2) ? 131072 : 65536;
            for (int j = 0; j < n; j++) begin
                lap = -longint'(stage_phi[(j + n - 2) % n])
                    + 16 * longint'(stage_phi[(j + n - 1) % n])
                    - 30 * longint'(stage_phi[j])
                    + 16 * longint'(stage_phi[(j + 1) % n])
                    - longint'(stage_phi[(j + 2) % n]);
                rate_phi[j] = stage_vel[j];
                rate_vel[j] = clamp32(lap * hi + ((lap * lo) >>> 16));
            end
            for (int j = 0; j < n; j++) begin
                acc_phi[j] = clamp32(longint'(acc_phi[j]) + w * rate_phi[j]);
                acc_vel[j] = clamp32(longint'(acc_vel[j]) + w * rate_vel[j]);
                if (s < 3) begin
                    stage_phi[j] = clamp32(longint'(phi_grid[j])
                        + floor_div(longint'(rate_phi[j]) * dt, den));
                    stage_vel[j] = clamp32(longint'(vel_grid[j])
                        + floor_div(longint'(rate_vel[j]) * dt, den));
                end
            end
        end
        for (int j = 0; j < n; j++) begin
            phi_grid[j] = clamp32(longint'(phi_grid[j])
                + floor_div(longint'(acc_phi[j]) * dt, 393216));
            vel_grid[j] = clamp32(longint'(vel_grid[j])
                + floor_div(longint'(acc_vel[j]) * dt, 393216));
        end
    endtask

    task automatic predict_word(input t_in w);
        t_out r;
        case (w.operation)
            OP_LOAD: begin
                phi_grid[w.index] = w.phi_in;
                vel_grid[w.index] = w.pi_in;
            end
            OP_RUN: begin
                for (int k = 0; k < int'(step_count); k++) advance_grid(active_points());
                r.kind = KIND_DONE;
                r.phi_out = '0;
                r.pi_out = '0;
                result_queue.push_back(r);
            end
            OP_READ: begin
                r.kind = KIND_READ;
                r.phi_out = phi_grid[w.index];
                r.pi_out = vel_grid[w.index];
                result_queue.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (result_queue.size() == 0) begin
            $error("result word with nothing expected: kind %0d", got.kind);
            o_failures++;
        end else begin
            want = result_queue.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                o_failures++;
            end
            if (got.phi_out !== want.phi_out) begin
                $error("phi_out: expected %0d, got %0d", want.phi_out, got.phi_out);
                o_failures++;
            end
            if (got.pi_out !== want.pi_out) begin
                $error("pi_out: expected %0d, got %0d", want.pi_out, got.pi_out);
                o_failures++;
            end
        end
    endtask

    initial begin
        o_failures = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_points = 11'd1024;
            dt_q = 17'd66;
            scale_q = 32'd218431488;
            step_count = 16'd1000;
            result_queue.delete();
        end else begin
            if (i_done) check_result(i_result);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_POINTS: grid_points = i_pwdata[10:0];
                    REG_DT:     dt_q = i_pwdata[16:0];
                    REG_SCALE:  scale_q = i_pwdata;
                    REG_STEPS:  step_count = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_word(i_word);
        end
        o_pending = result_queue.size();
    end

endmodule

// ===== bench/tb_wave_equation_rk4_stencil_core.sv =====
// top of the stencil core bench: clock, reset, word and register stimulus, verdict
// depends on wers_pkg, wave_equation_rk4_stencil_core and its checker
module tb_wave_equation_rk4_stencil_core;
    import wers_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_word;
    logic        o_done;
    t_out        o_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          failures;
    int          pending;

    logic        loaded [MAX_POINTS];
    int          points_now;
    int          words_sent;
    bit          no_gaps;
    longint      cycles;

    wave_equation_rk4_stencil_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_word(i_word),
        .o_done(o_done), .o_word(o_word), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wave_equation_rk4_stencil_core_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_word(i_word),
        .i_done(o_done), .i_result(o_word), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_failures(failures), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            3: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input int idx,
                             input logic [31:0] phi, input logic [31:0] vel);
        int gap;
        gap = 0;
        if (!no_gaps) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(5, 40);
            endcase
        end
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_word.operation = op;
        i_word.index = idx[IDX_W-1:0];
        i_word.phi_in = phi;
        i_word.pi_in = vel;
        do @(posedge i_clk); while (busy);
        if (op == OP_LOAD) loaded[idx] = 1'b1;
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_id, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (reg_id == REG_POINTS) begin
            points_now = (value[10:0] < 5) ? 5 :
                         (value[10:0] > MAX_POINTS) ? MAX_POINTS : int'(value[10:0]);
        end
    endtask

    task automatic run_grid();
        for (int j = 0; j < points_now; j++) begin
            if (!loaded[j]) send_word(OP_LOAD, j, pick_value(), pick_value());
        end
        send_word(OP_RUN, $urandom_range(0, 1023), $urandom, $urandom);
    endtask

    task automatic read_some();
        int idx;
        idx = $urandom_range(0, points_now + 3);
        if (idx >= MAX_POINTS) idx = 0;
        if (!loaded[idx]) idx = 0;
        if (loaded[idx]) send_word(OP_READ, idx, $urandom, $urandom);
    endtask

    task automatic random_config();
        case ($urandom_range(0, 5))
            0: write_reg(REG_POINTS, $urandom_range(0, 4));
            1: write_reg(REG_POINTS, $urandom_range(17, 40));
            2: write_reg(REG_POINTS, 5);
            default: write_reg(REG_POINTS, $urandom_range(5, 16));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_DT, 0);
            1: write_reg(REG_DT, 65536);
            2: write_reg(REG_DT, $urandom_range(0, 1000));
            default: write_reg(REG_DT, $urandom_range(0, 131071));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_SCALE, 0);
            1: write_reg(REG_SCALE, 32'hFFFFFFFF);
            2: write_reg(REG_SCALE, 32'd218431488);
            3: write_reg(REG_SCALE, $urandom_range(0, 32'h0003FFFF));
            default: write_reg(REG_SCALE, $urandom);
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_STEPS, 0);
            1: write_reg(REG_STEPS, 1);
            2: write_reg(REG_STEPS, $urandom_range(7, 20));
            default: write_reg(REG_STEPS, $urandom_range(1, 6));
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        points_now = MAX_POINTS;
        words_sent = 0;
        no_gaps = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++) loaded[j] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero steps still finishes; points below five act as five
        write_reg(REG_POINTS, 0);
        write_reg(REG_DT, 65536);
        write_reg(REG_SCALE, 32'hFFFFFFFF);
        write_reg(REG_STEPS, 65535);
        write_reg(REG_STEPS, 0);
        send_word(OP_LOAD, 0, 32'h7FFFFFFF, 32'h80000000);
        send_word(OP_LOAD, 1, 32'h80000000, 32'h7FFFFFFF);
        send_word(OP_LOAD, 2, 32'h0, 32'h0);
        send_word(OP_LOAD, 3, 32'h00010000, 32'hFFFFFFFF);
        send_word(OP_LOAD, 4, 32'hFFFF0000, 32'h00000001);
        send_word(OP_LOAD, 1023, 32'h12345678, 32'hEDCBA987);
        send_word(OP_READ, 1023, 32'h0, 32'h0);
        send_word(OP_NONE, 1023, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_word(OP_RUN, 0, 32'h0, 32'h0);
        send_word(OP_READ, 0, 32'h0, 32'h0);
        wait_idle();
        write_reg(REG_STEPS, 1);
        send_word(OP_RUN, 0, 32'h0, 32'h0);
        for (int j = 0; j < 5; j++) send_word(OP_READ, j, 32'h0, 32'h0);
        wait_idle();

        // points above the store act as the whole store
        write_reg(REG_POINTS, 2047);
        write_reg(REG_DT, 66);
        write_reg(REG_SCALE, 32'd218431488);
        run_grid();
        send_word(OP_READ, 7, 32'h0, 32'h0);
        send_word(OP_READ, 1023, 32'h0, 32'h0);
        wait_idle();

        while (words_sent < 1200) begin
            random_config();
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(60, 120)) begin
                case ($urandom_range(0, 19))
                    0, 1: run_grid();
                    2: send_word(OP_NONE, $urandom_range(0, 1023), $urandom, $urandom);
                    3, 4: send_word(OP_LOAD, $urandom_range(0, 1023), pick_value(),
                                    pick_value());
                    5, 6, 7, 8, 9, 10, 11: read_some();
                    default: send_word(OP_LOAD, $urandom_range(0, points_now + 3) % MAX_POINTS,
                                       pick_value(), pick_value());
                endcase
            end
            wait_idle();
        end

        wait_idle();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wers_pkg.sv
hw/rtl/wers_cell.sv
hw/rtl/wers_ctrl.sv
hw/rtl/wers_datapath.sv
hw/rtl/wave_equation_rk4_stencil_core.sv
bench/wave_equation_rk4_stencil_core_checker.sv
bench/tb_wave_equation_rk4_stencil_core.sv
